/* src/itoa_pkg.sv */
// Package: shared constants and types for the signed integer to decimal text unit.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

    // Width of the signed input value.
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
    // The factor 0.30103 is log10(2); one more digit covers the fraction.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    // Commands broadcast to every digit cell of the chain.
    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } t_cell_ctrl;

endpackage
`default_nettype wire

/* src/itoa_cell.sv */
// Module: one BCD digit cell of the binary to decimal conversion chain.
`timescale 1ns / 1ps
`default_nettype none
module itoa_cell
    import itoa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_bit,
    input  wire logic [3:0] i_digit,
    output logic            o_bit,
    output logic [3:0]      o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three to a digit of five or more, so that the next doubling
    // carries correctly into the neighbouring cell.
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.shift_bit) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctrl.shift_digit) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
`default_nettype wire

/* src/int32_to_decimal_ascii_unit.sv */
// Module: top level of the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction carries one signed integer; the unit answers with its decimal
// text, one ASCII character per output transaction, most significant first. Negative
// values start with a minus sign, leading zeros are dropped, zero gives a single '0',
// and the most negative value converts exactly. The final character carries o_is_last.
// The unit handles one value at a time: after a value is accepted, its magnitude is
// shifted bit by bit, most significant first, through a row of BCD digit cells. The
// digit row then shifts towards its top cell one digit per cycle, silently while the
// top digit is a leading zero and emitting a character otherwise; an emitting shift
// waits while the output register is full and not being taken. The whole digit row is
// walked for every value, whatever its length, and a negative value adds a step for
// its minus sign. The last character may still wait in the output register while the
// next value is accepted.
module int32_to_decimal_ascii_unit
    import itoa_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [6:0]                        o_char_code,
    output logic                              o_is_last
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag,   n_mag;
    logic                  r_neg,   n_neg;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LEFT_W-1:0]     r_left,  n_left;
    logic                  r_o_valid, n_o_valid;
    logic [6:0]            r_o_code,  n_o_code;
    logic                  r_o_last,  n_o_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_in_mag;
    logic                  w_slot_free;
    logic                  w_load_out;
    logic [3:0]            w_top;
    t_cell_ctrl            w_ctrl;

    // Bit and digit links of the cell chain; index 0 feeds the least
    // significant cell, the last index comes out of the top cell.
    logic [NUM_DIGITS:0]   w_bit;
    logic [3:0]            w_digit [0:NUM_DIGITS];

    // The magnitude is formed unsigned, so the most negative value gives
    // exactly 2^(VALUE_BITS-1) without overflow.
    assign w_raw    = $unsigned(i_value);
    assign w_in_mag = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    assign w_bit[0]   = r_mag[VALUE_BITS-1];
    assign w_digit[0] = 4'd0;
    assign w_top      = w_digit[NUM_DIGITS];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            itoa_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_bit[g]),
                .i_digit (w_digit[g]),
                .o_bit   (w_bit[g+1]),
                .o_digit (w_digit[g+1])
            );
        end
    endgenerate

    // The output register may take a new character when it is empty or
    // when its present one is being taken in this cycle.
    assign w_slot_free = !r_o_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_count    = r_count;
        n_left     = r_left;
        w_ctrl     = '0;
        w_load_out = 1'b0;
        n_o_code   = r_o_code;
        n_o_last   = r_o_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mag        = w_in_mag;
                    n_neg        = w_raw[VALUE_BITS-1];
                    n_count      = CNT_W'(VALUE_BITS);
                    w_ctrl.clear = 1'b1;
                    n_state      = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.shift_bit = 1'b1;
                n_mag            = r_mag << 1;
                n_count          = r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = r_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    w_load_out = 1'b1;
                    n_o_code   = ASCII_MINUS;
                    n_o_last   = 1'b0;
                    n_state    = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, but always keep the last digit.
                if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    w_ctrl.shift_digit = 1'b1;
                    n_left             = r_left - 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_load_out         = 1'b1;
                    w_ctrl.shift_digit = 1'b1;
                    n_o_code           = ASCII_ZERO + {3'b000, w_top};
                    n_o_last           = (r_left == LEFT_W'(1));
                    n_left             = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_o_valid = w_load_out || (r_o_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_count  <= n_count;
        r_left   <= n_left;
        r_o_code <= n_o_code;
        r_o_last <= n_o_last;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_char_code = r_o_code;
    assign o_is_last   = r_o_last;

`ifndef SYNTHESIS
    // The digit row is sized for the largest magnitude, so nothing may
    // carry out of the top cell during conversion.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_bit[NUM_DIGITS])
        else $error("carry out of the top digit cell");

    // Every character shown is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_code == ASCII_MINUS ||
                       (r_o_code >= ASCII_ZERO && r_o_code <= ASCII_ZERO + 7'd9)))
        else $error("character outside the expected set");

    // The digit count never runs out before the last digit is sent.
    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP || r_state == ST_EMIT) |-> (r_left != '0))
        else $error("digit count exhausted while digits remain");

    // Loading the final digit returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_state == ST_EMIT && r_left == LEFT_W'(1))
        |=> (r_state == ST_IDLE && o_is_last))
        else $error("final character did not end the transaction sequence");
`endif

endmodule
`default_nettype wire
